FILE: rtl/linear_probe_hash_table_unit_assert.svh
// Assertion macros shared by the checker files.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LPHT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lpht_pkg.sv
package lpht_pkg;

   localparam int CAPACITY_DEF    = 64;
   localparam int KEY_BYTES_DEF   = 8;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam int KEY_PORT_W   = 64;
   localparam int LEN_W        = 4;
   localparam int VALUE_PORT_W = 32;
   localparam int HASH_W       = 64;

   localparam logic [HASH_W-1:0] HASH_START = 64'd5381;
   localparam int                HASH_SHIFT = 5;

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_INSERT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_DUPLICATE = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

endpackage

FILE: rtl/lpht_hash.sv
// Iterative djb2 hash (one key byte per cycle) followed by the remainder by
// the table capacity. For a capacity that is not a power of two, fold the hash
// in 16-bit chunks weighted by 2**(16*j) mod CAPACITY, then reduce the folded
// sum by a reciprocal multiplication and one correcting subtract.
module lpht_hash
   import lpht_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_BYTES = KEY_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [8*KEY_BYTES-1:0]       key,
   input  logic [LEN_W-1:0]             len,
   output logic                         done,
   output logic [$clog2(CAPACITY)-1:0]  home
);

   localparam int KEY_W    = 8 * KEY_BYTES;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CHUNK_W  = 16;
   localparam int PROD_W   = CHUNK_W + IDX_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam bit CAP_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
   localparam logic [IDX_W:0]   CAP_EXT  = (IDX_W + 1)'(CAPACITY);
   localparam logic [31:0]      RECIP    = 32'((64'd1 << 32) / 64'(CAPACITY));
   localparam logic [IDX_W-1:0] WEIGHT_0 = IDX_W'(1);
   localparam logic [IDX_W-1:0] WEIGHT_1 = IDX_W'((64'd1 << 16) % 64'(CAPACITY));
   localparam logic [IDX_W-1:0] WEIGHT_2 = IDX_W'((64'd1 << 32) % 64'(CAPACITY));
   localparam logic [IDX_W-1:0] WEIGHT_3 = IDX_W'((64'd1 << 48) % 64'(CAPACITY));

   typedef enum logic [6:0] {
      H_IDLE = 7'b0000001,
      H_BYTE = 7'b0000010,
      H_MOD  = 7'b0000100,
      H_FOLD = 7'b0001000,
      H_QUOT = 7'b0010000,
      H_REM  = 7'b0100000,
      H_FIX  = 7'b1000000
   } hash_state_type;

   hash_state_type        state_ff, state_in;
   logic [HASH_W-1:0]     h_ff, h_in;
   logic [KEY_W-1:0]      key_sh_ff, key_sh_in;
   logic [LEN_W-1:0]      cnt_ff, cnt_in;
   logic [1:0]            fold_cnt_ff, fold_cnt_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [ACC_W-1:0]      quot_ff, quot_in;
   logic [IDX_W:0]        rem_ff, rem_in;
   logic [IDX_W-1:0]      home_ff, home_in;
   logic                  done_ff, done_in;

   logic [HASH_W-1:0]     byte_ext;
   logic [HASH_W-1:0]     h_step;
   logic [IDX_W-1:0]      weight;
   logic [PROD_W-1:0]     fold_term;
   logic [ACC_W+31:0]     quot_prod;
   logic [ACC_W+IDX_W:0]  quot_back;

   // shared shift-add step: h * 33 + sign-extended byte
   assign byte_ext = {{(HASH_W - 8){key_sh_ff[7]}}, key_sh_ff[7:0]};
   assign h_step   = (h_ff << HASH_SHIFT) + h_ff + byte_ext;

   // weight of the current 16-bit chunk, low chunk first
   always_comb begin
      unique case (fold_cnt_ff)
         2'd0: weight = WEIGHT_0;
         2'd1: weight = WEIGHT_1;
         2'd2: weight = WEIGHT_2;
         2'd3: weight = WEIGHT_3;
      endcase
   end

   assign fold_term = h_ff[CHUNK_W-1:0] * weight;
   // quotient estimate is low by at most one
   assign quot_prod = acc_ff * RECIP;
   assign quot_back = quot_ff * CAP_EXT;

   always_comb begin
      state_in    = state_ff;
      h_in        = h_ff;
      key_sh_in   = key_sh_ff;
      cnt_in      = cnt_ff;
      fold_cnt_in = fold_cnt_ff;
      acc_in      = acc_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      home_in     = home_ff;
      done_in     = 1'b0;
      unique case (state_ff)
         H_IDLE: begin
            if (start) begin
               h_in      = HASH_START;
               key_sh_in = key;
               cnt_in    = len;
               state_in  = (len == '0) ? H_MOD : H_BYTE;
            end
         end
         H_BYTE: begin
            h_in      = h_step;
            key_sh_in = key_sh_ff >> 8;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == LEN_W'(1)) begin
               state_in = H_MOD;
            end
         end
         H_MOD: begin
            if (CAP_POW2) begin
               home_in  = h_ff[IDX_W-1:0];
               done_in  = 1'b1;
               state_in = H_IDLE;
            end else begin
               acc_in      = '0;
               fold_cnt_in = '0;
               state_in    = H_FOLD;
            end
         end
         H_FOLD: begin
            // accumulate one weighted chunk a cycle
            acc_in      = acc_ff + ACC_W'(fold_term);
            h_in        = h_ff >> CHUNK_W;
            fold_cnt_in = fold_cnt_ff + 1'b1;
            if (fold_cnt_ff == 2'd3) begin
               state_in = H_QUOT;
            end
         end
         H_QUOT: begin
            quot_in  = quot_prod[ACC_W+31:32];
            state_in = H_REM;
         end
         H_REM: begin
            rem_in   = (IDX_W + 1)'(acc_ff - quot_back[ACC_W-1:0]);
            state_in = H_FIX;
         end
         H_FIX: begin
            home_in  = (rem_ff >= CAP_EXT) ? IDX_W'(rem_ff - CAP_EXT) : rem_ff[IDX_W-1:0];
            done_in  = 1'b1;
            state_in = H_IDLE;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      h_ff        <= h_in;
      key_sh_ff   <= key_sh_in;
      cnt_ff      <= cnt_in;
      fold_cnt_ff <= fold_cnt_in;
      acc_ff      <= acc_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      home_ff     <= home_in;
   end

   assign done = done_ff;
   assign home = home_ff;

endmodule

FILE: rtl/lpht_slot_ram.sv
// Slot store: one write port, one registered read port.
module lpht_slot_ram
   import lpht_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int WIDTH = 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/linear_probe_hash_table_unit.sv
// Linear-probing hash table, CAPACITY slots, keys of up to KEY_BYTES bytes.
// Each request beat is a lookup or an insert and yields exactly one response
// beat. After reset the block sweeps the slot memory once, one slot a cycle,
// and req_stall stays high until the sweep is done and the first beat can be
// taken. One request is worked on at a time: the djb2 hash is built by a
// shared shift-add step one key byte a cycle, the home slot is taken as the
// low bits of the hash when CAPACITY is a power of two and otherwise by a
// chunk fold and reciprocal remainder, and every probed slot takes a memory
// read, then a compare; the single read port of the slot memory paces the
// probe. A full scan visits all CAPACITY slots. The response register lets
// the next request be taken while a response still waits on rsp_stall.
module linear_probe_hash_table_unit
   import lpht_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int KEY_BYTES   = KEY_BYTES_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_func,
   input  logic [KEY_PORT_W-1:0]    req_key_bytes,
   input  logic [LEN_W-1:0]         req_key_length,
   input  logic [VALUE_PORT_W-1:0]  req_value_in,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [VALUE_PORT_W-1:0]  rsp_value_out
);

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int KEY_W   = 8 * KEY_BYTES;
   localparam int ENTRY_W = 1 + LEN_W + KEY_W + VALUE_WIDTH;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(KEY_BYTES);

   typedef enum logic [5:0] {
      ST_CLEAR   = 6'b000001,
      ST_IDLE    = 6'b000010,
      ST_HASH    = 6'b000100,
      ST_READ    = 6'b001000,
      ST_COMPARE = 6'b010000,
      ST_FINISH  = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         ptr_ff, ptr_in;          // sweep index, then probe slot
   logic [IDX_W-1:0]         scanned_ff, scanned_in;  // slots probed so far, minus one
   logic                     func_ff, func_in;
   logic [KEY_W-1:0]         key_ff, key_in;
   logic [LEN_W-1:0]         len_ff, len_in;
   logic [VALUE_WIDTH-1:0]   value_ff, value_in;
   status_type               res_status_ff, res_status_in;
   logic [VALUE_PORT_W-1:0]  res_value_ff, res_value_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [VALUE_PORT_W-1:0]  rsp_value_ff, rsp_value_in;

   logic                     req_beat;
   logic                     out_free;
   logic [LEN_W-1:0]         len_clamp;
   logic [KEY_PORT_W-1:0]    key_mask;
   logic [63:0]              value_ext;

   logic                     hash_done;
   logic [IDX_W-1:0]         hash_home;

   logic                     wr_en;
   logic [ENTRY_W-1:0]       wr_data;
   logic                     rd_en;
   logic [ENTRY_W-1:0]       rd_data;
   logic                     rd_valid;
   logic [LEN_W-1:0]         rd_len;
   logic [KEY_W-1:0]         rd_key;
   logic [VALUE_WIDTH-1:0]   rd_value;
   logic [63:0]              rd_value_ext;
   logic                     rd_match;

   // Take a request beat only when idle; the response register is separate.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Clamp an overlong length and drop key bytes beyond it, so hash,
   // compare and stored key all see the same canonical key.
   assign len_clamp = (req_key_length > MAX_LEN) ? MAX_LEN : req_key_length;

   always_comb begin
      for (int i = 0; i < KEY_PORT_W / 8; i++) begin
         key_mask[i*8 +: 8] = (LEN_W'(i) < len_clamp) ? req_key_bytes[i*8 +: 8] : 8'h00;
      end
   end

   assign value_ext = 64'(req_value_in);

   lpht_hash #(
      .CAPACITY  (CAPACITY),
      .KEY_BYTES (KEY_BYTES)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (req_beat),
      .key   (key_mask[KEY_W-1:0]),
      .len   (len_clamp),
      .done  (hash_done),
      .home  (hash_home)
   );

   // Slot entry: valid, length, key, value (MSB to LSB).
   assign rd_valid     = rd_data[ENTRY_W-1];
   assign rd_len       = rd_data[ENTRY_W-2 -: LEN_W];
   assign rd_key       = rd_data[VALUE_WIDTH +: KEY_W];
   assign rd_value     = rd_data[VALUE_WIDTH-1:0];
   assign rd_value_ext = 64'(rd_value);
   assign rd_match     = (rd_len == len_ff) && (rd_key == key_ff);

   // The sweep writes empty entries; an insert writes the first empty slot.
   assign wr_en   = (state_ff == ST_CLEAR) ||
                    ((state_ff == ST_COMPARE) && (func_ff == FUNC_INSERT) && !rd_valid);
   assign wr_data = (state_ff == ST_CLEAR) ? '0 : {1'b1, len_ff, key_ff, value_ff};
   assign rd_en   = (state_ff == ST_READ);

   lpht_slot_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (ENTRY_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ptr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      scanned_in    = scanned_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      len_in        = len_ff;
      value_in      = value_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;

      // drop the response once it has been taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // advance the sweep, one slot a cycle
            if (ptr_ff == LAST_IDX) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               func_in  = req_func;
               key_in   = key_mask[KEY_W-1:0];
               len_in   = len_clamp;
               value_in = value_ext[VALUE_WIDTH-1:0];
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            // hold until the home slot is known
            if (hash_done) begin
               ptr_in     = hash_home;
               scanned_in = '0;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            res_value_in = '0;
            if (!rd_valid) begin
               // empty slot ends the probe: insert here or miss
               res_status_in = (func_ff == FUNC_INSERT) ? STATUS_OK : STATUS_NOT_FOUND;
               state_in      = ST_FINISH;
            end else if (rd_match) begin
               if (func_ff == FUNC_INSERT) begin
                  res_status_in = STATUS_DUPLICATE;
               end else begin
                  res_status_in = STATUS_OK;
                  res_value_in  = rd_value_ext[VALUE_PORT_W-1:0];
               end
               state_in = ST_FINISH;
            end else if (scanned_ff == LAST_IDX) begin
               // whole table scanned without a hit or a hole
               res_status_in = (func_ff == FUNC_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
               state_in      = ST_FINISH;
            end else begin
               ptr_in     = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
               scanned_in = scanned_ff + 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_FINISH: begin
            // hold the result until the response register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            ptr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scanned_ff    <= scanned_in;
      func_ff       <= func_in;
      key_ff        <= key_in;
      len_ff        <= len_in;
      value_ff      <= value_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;

endmodule

FILE: rtl/lpht_checker.sv
`include "linear_probe_hash_table_unit_assert.svh"

// Port-level checks of the hash table unit.
module lpht_checker
   import lpht_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [1:0]               rsp_status,
   input logic [VALUE_PORT_W-1:0]  rsp_value_out
);

   // the slot sweep keeps requests out right after reset
   `LPHT_ASSERT_NEXT(a_stall_after_reset, clock, 1'b0, reset, req_stall, "request taken during slot sweep")

   // one request at a time: busy right after a request beat
   `LPHT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "second request taken while busy")

   // only a successful lookup carries a value
   `LPHT_ASSERT_IMPL(a_value_zero, clock, reset, rsp_valid && (rsp_status != STATUS_OK), rsp_value_out == '0, "non-zero value on a failed request")

   // a stalled response holds
   `LPHT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_value_out), "stalled response changed")

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_value_out (rsp_value_out)
);
